>>> hw/rtl/itda_pkg.sv
// Package for the signed integer to decimal ASCII converter.
// Holds widths, character codes and the word type carried between front and back.
// No dependencies.
`timescale 1ns / 1ps
package itda_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int DIG_W       = 4;
  localparam int NDIG        = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_W       = NDIG * DIG_W;
  localparam int IDX_W       = $clog2(NDIG);
  localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
  localparam int CHAR_W      = 6;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic                   negative;
    logic [VALUE_WIDTH-1:0] mag;
  } queue_word_t;

endpackage

>>> hw/rtl/int_to_decimal_ascii.sv
// Top level: signed integer to decimal ASCII text, one character per output word.
// The back end converts one value at a time with the serial shift-add-3 converter and takes
// a new value only after emitting the last character of the previous one; the front end and
// the queue can hold further values meanwhile.
// Reset: synchronous, clears queue and handshake state; no storage needs clearing.
// Depends on itda_pkg, itda_front, itda_queue, itda_back.
`timescale 1ns / 1ps
module int_to_decimal_ascii import itda_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   value_valid,
  output logic                   value_ready,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic                   char_valid,
  input  logic                   char_ready,
  output logic [CHAR_W-1:0]      character,
  output logic                   last_char
);

  logic        f_valid;
  logic        f_ready;
  queue_word_t f_word;
  logic        q_valid;
  logic        q_ready;
  queue_word_t q_word;

  itda_front u_front (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .value_ready (value_ready),
    .value       (value),
    .word_valid  (f_valid),
    .word_ready  (f_ready),
    .word        (f_word)
  );

  itda_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_word  (f_word),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_word   (q_word)
  );

  itda_back u_back (
    .clk        (clk),
    .rst        (rst),
    .word_valid (q_valid),
    .word_ready (q_ready),
    .word       (q_word),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .character  (character),
    .last_char  (last_char)
  );

endmodule

>>> hw/rtl/itda_front.sv
// Front end: accepts one signed value and splits it into sign and unsigned magnitude.
// Depends on itda_pkg.
`timescale 1ns / 1ps
module itda_front import itda_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   value_valid,
  output logic                   value_ready,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic                   word_valid,
  input  logic                   word_ready,
  output queue_word_t            word
);

  logic neg;

  assign neg         = value[VALUE_WIDTH-1];
  assign value_ready = !word_valid || word_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (value_ready) begin
      word_valid <= value_valid;
    end
    if (value_valid && value_ready) begin
      word.negative <= neg;
      word.mag      <= neg ? (~value + VALUE_WIDTH'(1)) : value;
    end
  end

endmodule

>>> hw/rtl/itda_queue.sv
// Short queue between front and back ends.
// Depends on itda_pkg.
`timescale 1ns / 1ps
module itda_queue import itda_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push_valid,
  output logic        push_ready,
  input  queue_word_t push_word,
  output logic        pop_valid,
  input  logic        pop_ready,
  output queue_word_t pop_word
);

  queue_word_t       entry [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign push_ready = count != QCNT_W'(QDEPTH);
  assign pop_valid  = count != '0;
  assign pop_word   = entry[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
    if (push) begin
      entry[wr_ptr] <= push_word;
    end
  end

endmodule

>>> hw/rtl/itda_back.sv
// Back end: shift-add-3 binary to BCD conversion, then emits a minus sign if negative, and the digits.
// Depends on itda_pkg.
`timescale 1ns / 1ps
module itda_back import itda_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              word_valid,
  output logic              word_ready,
  input  queue_word_t       word,
  output logic              char_valid,
  input  logic              char_ready,
  output logic [CHAR_W-1:0] character,
  output logic              last_char
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SIGN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]             state;
  logic [VALUE_WIDTH-1:0] mag_sh;
  logic                   negative;
  logic [BCD_W-1:0]       bcd;
  logic [BCD_W-1:0]       bcd_adj;
  logic [BCD_W-1:0]       bcd_next;
  logic [CNT_W-1:0]       cnt;
  logic [IDX_W-1:0]       idx;
  logic [IDX_W-1:0]       top;
  logic [DIG_W-1:0]       digit;
  logic                   load_out;
  logic                   emit;

  assign word_ready = state == ST_IDLE;
  assign load_out   = !char_valid || char_ready;
  assign emit       = load_out && (state inside {ST_SIGN, ST_EMIT});
  assign digit      = bcd[idx*DIG_W +: DIG_W];

  always_comb begin
    logic [DIG_W-1:0] d;
    for (int i = 0; i < NDIG; i++) begin
      d = bcd[i*DIG_W +: DIG_W];
      bcd_adj[i*DIG_W +: DIG_W] = (d >= DIG_W'(5)) ? d + DIG_W'(3) : d;
    end
    bcd_next = {bcd_adj[BCD_W-2:0], mag_sh[VALUE_WIDTH-1]};
  end

  always_comb begin
    top = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_next[i*DIG_W +: DIG_W] != '0) begin
        top = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      char_valid <= 1'b0;
    end else begin
      if (emit) begin
        char_valid <= 1'b1;
      end else if (char_ready) begin
        char_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (word_valid) begin
            mag_sh   <= word.mag;
            negative <= word.negative;
            bcd      <= '0;
            cnt      <= '0;
            state    <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd    <= bcd_next;
          mag_sh <= mag_sh << 1;
          cnt    <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(VALUE_WIDTH - 1)) begin
            idx   <= top;
            state <= negative ? ST_SIGN : ST_EMIT;
          end
        end
        ST_SIGN: begin
          if (load_out) begin
            character <= ASCII_MINUS;
            last_char <= 1'b0;
            state     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (load_out) begin
            character <= ASCII_ZERO + CHAR_W'(digit);
            last_char <= idx == '0;
            idx       <= idx - IDX_W'(1);
            if (idx == '0) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
